### src/assert_macros.svh
// Assertion helper macros for the affine transform unit.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

### src/amt_pkg.sv
// Package for the affine transform unit: request codes, data types,
// sine table and fold function. No dependencies.
package amt_pkg;
   localparam logic [1:0] REQ_IDENTITY  = 2'd0;
   localparam logic [1:0] REQ_TRANSLATE = 2'd1;
   localparam logic [1:0] REQ_SCALE     = 2'd2;
   localparam logic [1:0] REQ_ROTATE    = 2'd3;

   typedef logic signed [15:0] coeff_type;
   typedef logic signed [31:0] trans_type;

   // sin of 0..90 degrees, 16 fraction bits
   localparam logic [16:0] SIN_Q16 [0:90] = '{
      17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
      17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
      17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
      17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
      17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
      17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
      17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
      17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
      17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
      17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
      17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
      17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
      17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536};

   // folded table index and sign for an angle 0..359
   function automatic logic [7:0] sin_fold(input logic [8:0] a);
      logic [8:0] i;
      logic       n;
      begin
         n = 1'b0;
         if (a <= 9'd90) i = a;
         else if (a <= 9'd180) i = 9'd180 - a;
         else if (a <= 9'd270) begin i = a - 9'd180; n = 1'b1; end
         else begin i = 9'd360 - a; n = 1'b1; end
         sin_fold = {n, i[6:0]};
      end
   endfunction
endpackage

### src/amt_sincos.sv
// Registered sine/cosine lookup for whole degrees at FRAC_BITS.
// Depends on amt_pkg.
module amt_sincos #(
   parameter int FRAC_BITS = 12
) (
   input  logic                clock,
   input  logic [8:0]          angle,
   output logic signed [17:0]  sin_val,
   output logic signed [17:0]  cos_val
);
   import amt_pkg::*;
   localparam int SH = 16 - FRAC_BITS;
   logic [8:0]  cang;
   logic [7:0]  fs, fc;
   logic signed [17:0] sin_ff, cos_ff, sin_in, cos_in;

   function automatic logic signed [17:0] conv(input logic [7:0] f);
      logic [17:0] raw, mag;
      begin
         raw = {1'b0, SIN_Q16[f[6:0]]};
         if (SH > 0) mag = (raw + (18'd1 << (SH - 1))) >> SH;
         else mag = raw << (-SH);
         conv = f[7] ? -$signed(mag) : $signed(mag);
      end
   endfunction

   // cosine angle is (a + 90) mod 360
   always_comb begin
      cang = (angle >= 9'd270) ? angle - 9'd270 : angle + 9'd90;
      fs = sin_fold(angle);
      fc = sin_fold(cang);
      sin_in = conv(fs);
      cos_in = conv(fc);
   end
   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end
   assign sin_val = sin_ff;
   assign cos_val = cos_ff;
endmodule

### src/amt_mac.sv
// Multiply-accumulate for matrix and translation products; rounding and
// saturation are applied by the caller. Depends on nothing beyond its ports.
module amt_mac (
   input  logic               clock,
   input  logic               clr,
   input  logic               en,
   input  logic signed [19:0] a,
   input  logic signed [31:0] b,
   output logic signed [53:0] acc
);
   logic signed [53:0] acc_ff, acc_in;
   always_comb begin
      acc_in = acc_ff;
      if (clr) acc_in = 54'sd0;
      else if (en) acc_in = acc_ff + 54'(a) * 54'(b);
   end
   always_ff @(posedge clock) acc_ff <= acc_in;
   assign acc = acc_ff;
endmodule

### src/affine_matrix_transform_unit.sv
// Affine transform unit: 3x3 Q-format matrix plus translation in a small RAM.
// Uses amt_pkg, amt_sincos, amt_mac and assert_macros.svh.
// Rotation applies each axis with a nonzero angle by read-multiply-write passes
// through one MAC into a scratch matrix, which is then copied back.
// One item at a time; the next is accepted in the cycle after the result transaction.
// Reset: synchronous; a sweep writes identity/zero before the first request.
module affine_matrix_transform_unit #(
   parameter int FRAC_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata: [1:0] req_type, [21:2] operand_x, [41:22] operand_y,
   // [61:42] operand_z, [63:62] zero
   input  logic [63:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata: row0_col0..row2_col2 at 16 bits each from [15:0] up to
   // [143:128], then trans_x [175:144], trans_y [207:176], trans_z [239:208]
   output logic [239:0] rsp_tdata
);
   import amt_pkg::*;
`include "assert_macros.svh"

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_ID = 4'd2, S_TR = 4'd3,
      S_SC = 4'd4, S_AX = 4'd5, S_RD = 4'd6, S_MAC = 4'd7, S_WB = 4'd8,
      S_COPY = 4'd9, S_OUT = 4'd10, S_WAIT = 4'd11;
   localparam logic signed [31:0] ONE_SAT =
      (FRAC_BITS >= 15) ? 32'sd32767 : (32'sd1 <<< FRAC_BITS);

   // state RAM: 0..8 matrix, 9..11 translation, 16..24 scratch matrix
   logic [31:0] mem [0:31];
   logic [31:0] rd_ff;
   logic        we;
   logic [4:0]  wa, ra;
   logic [31:0] wd;

   logic [3:0]  st_ff, st_in;
   logic [1:0]  typ_ff, typ_in;
   logic signed [19:0] op_ff [0:2];
   logic [1:0]  axis_ff, axis_in;
   logic [3:0]  idx_ff, idx_in;     // entry 0..11
   logic [1:0]  k_ff, k_in;         // term / pipeline step
   logic [8:0]  ang;
   logic signed [17:0] s_v, c_v;
   logic        clr, en;
   logic signed [19:0] ma;
   logic signed [31:0] mb;
   logic signed [53:0] acc;
   logic        rv_ff, rv_in;
   logic [239:0] rdat_ff;
   logic signed [19:0] a_cur;
   logic signed [20:0] a_wrap;

   // current axis angle, wrapped once
   always_comb begin
      a_cur = op_ff[axis_ff];
      a_wrap = (a_cur < 0) ? 21'(a_cur) + 21'sd360 : 21'(a_cur);
      ang = a_wrap[8:0];
   end

   amt_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc (.clock, .angle(ang), .sin_val(s_v),
      .cos_val(c_v));
   amt_mac u_mac (.clock, .clr, .en, .a(ma), .b(mb), .acc);

   // rotation weight w[r][k] for the current axis
   function automatic logic signed [19:0] wgt(input logic [1:0] ax, input logic [1:0] r,
         input logic [1:0] kk, input logic signed [17:0] s, input logic signed [17:0] c);
      logic signed [19:0] one, sv, cv;
      begin
         one = 20'sd1 <<< FRAC_BITS; sv = 20'(s); cv = 20'(c); wgt = '0;
         unique case (ax)
            2'd0: begin
               if (r == 0 && kk == 0) wgt = one;
               if (r == 1 && kk == 1) wgt = cv;
               if (r == 1 && kk == 2) wgt = -sv;
               if (r == 2 && kk == 1) wgt = sv;
               if (r == 2 && kk == 2) wgt = cv;
            end
            2'd1: begin
               if (r == 1 && kk == 1) wgt = one;
               if (r == 0 && kk == 0) wgt = cv;
               if (r == 0 && kk == 2) wgt = -sv;
               if (r == 2 && kk == 0) wgt = sv;
               if (r == 2 && kk == 2) wgt = cv;
            end
            default: begin
               if (r == 2 && kk == 2) wgt = one;
               if (r == 0 && kk == 0) wgt = cv;
               if (r == 0 && kk == 1) wgt = -sv;
               if (r == 1 && kk == 0) wgt = sv;
               if (r == 1 && kk == 1) wgt = cv;
            end
         endcase
      end
   endfunction

   function automatic logic [1:0] rowof(input logic [3:0] i);
      rowof = (i < 4'd3) ? 2'd0 : (i < 4'd6) ? 2'd1 : 2'd2;
   endfunction
   function automatic logic [1:0] colof(input logic [3:0] i);
      colof = 2'(i - 4'(rowof(i)) * 4'd3);
   endfunction
   function automatic logic signed [53:0] rnd(input logic signed [53:0] v);
      rnd = (v + (54'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction
   function automatic logic [31:0] s16(input logic signed [53:0] v);
      s16 = (v > 54'sd32767) ? 32'h7fff : (v < -54'sd32768) ? 32'hffff8000 :
         {{16{v[15]}}, v[15:0]};
   endfunction
   function automatic logic [31:0] s32(input logic signed [53:0] v);
      s32 = (v > 54'sd2147483647) ? 32'h7fffffff :
         (v < -54'sd2147483648) ? 32'h80000000 : v[31:0];
   endfunction

   logic signed [53:0] tsum;
   logic [1:0] rr, cc;
   logic       skip_ax, bad_ax;

   always_comb begin
      st_in = st_ff; typ_in = typ_ff; axis_in = axis_ff; idx_in = idx_ff; k_in = k_ff;
      rv_in = rv_ff; we = 1'b0; wa = 5'd0; wd = '0; ra = 5'(idx_ff);
      clr = 1'b0; en = 1'b0; ma = '0; mb = '0;
      rr = rowof(idx_ff); cc = colof(idx_ff);
      tsum = 54'(signed'(rd_ff)) + (54'(op_ff[2'(idx_ff - 4'd9)]) <<< FRAC_BITS);
      skip_ax = (a_cur == 20'sd0);
      bad_ax = (a_wrap < 0) || (a_wrap >= 21'sd360);
      if (rsp_tvalid && rsp_tready) rv_in = 1'b0;
      unique case (st_ff)
         S_CLEAR, S_ID: begin
            we = 1'b1; wa = 5'(idx_ff);
            wd = (idx_ff > 4'd8) ? 32'd0 :
               ((idx_ff == 0 || idx_ff == 4 || idx_ff == 8) ? ONE_SAT : 32'd0);
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd11) begin
               idx_in = 4'd0; st_in = (st_ff == S_CLEAR) ? S_IDLE : S_OUT; k_in = 2'd0;
            end
         end
         S_IDLE: begin
            idx_in = 4'd0; k_in = 2'd0; axis_in = 2'd0;
            if (req_tvalid && req_tready) begin
               typ_in = req_tdata[1:0];
               unique case (req_tdata[1:0])
                  REQ_IDENTITY:  st_in = S_ID;
                  REQ_TRANSLATE: begin st_in = S_TR; idx_in = 4'd9; end
                  REQ_SCALE:     st_in = S_SC;
                  default:       st_in = S_AX;
               endcase
            end
         end
         S_TR: begin
            // k 0: read issued, k 1: data ready
            if (k_ff == 2'd0) k_in = 2'd1;
            else begin
               we = 1'b1; wa = 5'(idx_ff); wd = s32(tsum); k_in = 2'd0;
               idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd11) begin idx_in = 4'd0; st_in = S_OUT; end
            end
         end
         S_SC: begin
            // k 0 read, k 1 multiply, k 2 write
            clr = (k_ff == 2'd0);
            en = (k_ff == 2'd1);
            ma = op_ff[(idx_ff > 4'd8) ? 2'(idx_ff - 4'd9) : rr];
            mb = signed'(rd_ff);
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               we = 1'b1; wa = 5'(idx_ff);
               wd = (idx_ff > 4'd8) ? s32(rnd(acc)) : s16(rnd(acc));
               k_in = 2'd0; idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd11) begin idx_in = 4'd0; st_in = S_OUT; end
            end
         end
         S_AX: begin
            idx_in = 4'd0; k_in = 2'd0;
            if (skip_ax) begin
               if (axis_ff == 2'd2) st_in = S_OUT; else axis_in = axis_ff + 2'd1;
            end else if (bad_ax) st_in = S_OUT;
            else st_in = S_RD;   // table output valid next cycle
         end
         S_RD: begin
            // read M[k][c] for first term
            ra = 5'(4'(k_ff) * 4'd3 + 4'(cc)); clr = 1'b1; st_in = S_MAC;
         end
         S_MAC: begin
            ma = wgt(axis_ff, rr, k_ff, s_v, c_v); mb = signed'(rd_ff); en = 1'b1;
            ra = 5'(4'(k_ff + 2'd1) * 4'd3 + 4'(cc));
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd2) begin k_in = 2'd0; st_in = S_WB; end
         end
         S_WB: begin
            we = 1'b1; wa = 5'd16 + 5'(idx_ff); wd = s16(rnd(acc));
            idx_in = idx_ff + 4'd1; st_in = S_RD;
            if (idx_ff == 4'd8) begin idx_in = 4'd0; st_in = S_COPY; end
         end
         S_COPY: begin
            // scratch back to matrix: k 0 read, k 1 write
            ra = 5'd16 + 5'(idx_ff);
            if (k_ff == 2'd0) k_in = 2'd1;
            else begin
               we = 1'b1; wa = 5'(idx_ff); wd = rd_ff; k_in = 2'd0;
               ra = 5'd16 + 5'(idx_ff + 4'd1);
               idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd8) begin
                  idx_in = 4'd0;
                  if (axis_ff == 2'd2) st_in = S_OUT;
                  else begin axis_in = axis_ff + 2'd1; st_in = S_AX; end
               end
            end
         end
         S_OUT: begin
            // gather all 12 words into the result register
            ra = 5'(idx_ff);
            if (k_ff == 2'd0) k_in = 2'd1;
            else begin
               ra = 5'(idx_ff + 4'd1); idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd11) begin idx_in = 4'd0; k_in = 2'd0; st_in = S_WAIT; end
            end
         end
         S_WAIT: begin
            if (!rv_ff) begin rv_in = 1'b1; st_in = S_IDLE; end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // RAM write/read
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; idx_ff <= 4'd0; k_ff <= 2'd0; axis_ff <= 2'd0;
         typ_ff <= REQ_IDENTITY; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; idx_ff <= idx_in; k_ff <= k_in; axis_ff <= axis_in;
         typ_ff <= typ_in; rv_ff <= rv_in;
      end
   end

   // operands and result words
   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && req_tvalid && req_tready) begin
         op_ff[0] <= req_tdata[21:2]; op_ff[1] <= req_tdata[41:22];
         op_ff[2] <= req_tdata[61:42];
      end
      if (st_ff == S_OUT && k_ff == 2'd1) begin
         if (idx_ff < 4'd9) rdat_ff[16*idx_ff +: 16] <= rd_ff[15:0];
         else rdat_ff[144 + 32*(idx_ff - 4'd9) +: 32] <= rd_ff;
      end
   end

   // new request only once the result register has been emptied
   assign req_tready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rdat_ff;

   `ASSERT_IMPLIES(a_ready_idle, clock, reset, req_tready, st_ff == S_IDLE, "ready outside idle")
   `ASSERT_NEXT(a_take_busy, clock, reset, req_tvalid && req_tready, !req_tready, "double accept")
   `ASSERT_IMPLIES(a_we_range, clock, reset, we, wa < 5'd12 || (wa >= 5'd16 && wa < 5'd25),
      "write outside state RAM map")
endmodule
